FILE: rtl/lkvc_pkg.sv
// Package for the LRU keyed value cache: field widths, codes and the
// structs that pass between the top level and the row of cells.
// No dependencies.
package lkvc_pkg;

	localparam int KEY_W       = 32;
	localparam int VAL_W       = 16;
	localparam int STAMP_W     = 32;
	localparam int ENTRIES_DEF = 32;

	localparam logic ACT_SET = 1'b0;
	localparam logic ACT_GET = 1'b1;

	// search word that walks down the row, one cell per cycle
	typedef struct packed {
		logic               vld;
		logic               is_get;
		logic [KEY_W-1:0]   key;
		logic               hit;        // a cell already matched the key
		logic [VAL_W-1:0]   hit_val;
		logic               has_empty;  // first empty slot already found
		logic               vic_set;    // a victim candidate is held
		logic [STAMP_W-1:0] vic_stamp;
	} lkvc_tok_t;

	// update broadcast to every cell at the end of a set scan
	typedef struct packed {
		logic               en;
		logic               hit;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   val;
		logic [STAMP_W-1:0] stamp;
	} lkvc_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} lkvc_state_t;

endpackage

FILE: rtl/lkvc_cell.sv
// One slot of the cache: key, value and age stamp, plus one stage of the
// search word that passes through it. Depends on lkvc_pkg.
module lkvc_cell import lkvc_pkg::*; #(
	parameter int IDX_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lkvc_tok_t        tok_i,
	input  logic [IDX_W-1:0] vic_idx_i,
	output lkvc_tok_t        tok_o,
	output logic [IDX_W-1:0] vic_idx_o,
	input  lkvc_wr_t         wr_i,
	input  logic [IDX_W-1:0] wr_idx_i
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [STAMP_W-1:0] stamp_q;

	lkvc_tok_t        tok_nxt;
	logic [IDX_W-1:0] vic_nxt;
	lkvc_tok_t        tok_s1;
	logic [IDX_W-1:0] vic_idx_s1;
	logic             wr_sel;

	always_comb begin
		tok_nxt = tok_i;
		vic_nxt = vic_idx_i;
		if (!tok_i.hit && tok_i.key != '0 && key_q == tok_i.key) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_val = val_q;
		end
		if (!tok_i.has_empty) begin
			if (key_q == '0) begin
				tok_nxt.has_empty = 1'b1;
				vic_nxt           = MY_IDX;
			end else if (!tok_i.vic_set || stamp_q < tok_i.vic_stamp) begin
				// strict compare keeps the lowest index on ties
				tok_nxt.vic_set   = 1'b1;
				tok_nxt.vic_stamp = stamp_q;
				vic_nxt           = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		vic_idx_s1 <= vic_nxt;
	end

	assign tok_o     = tok_s1;
	assign vic_idx_o = vic_idx_s1;

	// hit rewrites the slot holding the key; miss fills the chosen victim
	assign wr_sel = wr_i.en && (wr_i.hit ? (key_q == wr_i.key) : (wr_idx_i == MY_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_sel) begin
			key_q <= wr_i.key;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			val_q   <= wr_i.val;
			stamp_q <= wr_i.stamp;
		end
	end

endmodule

FILE: rtl/lru_keyed_value_cache.sv
// A get's search word passes the input register and each cell register, then its result
// is registered at the output. A get or effective set stalls the input while it walks the
// row, a get until its result loads; an ignored set (zero node or value) is not stalled.
// Reset (arst_n low, asynchronous): all slots empty, stamp counter zero, no word pending.
// Top level of the LRU keyed value cache. Depends on lkvc_pkg and lkvc_cell.
module lru_keyed_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [KEY_W-1:0]        node_id,
	input  logic signed [VAL_W-1:0] rssi_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] stored_rssi
);

	localparam int IDX_W = $clog2(ENTRIES);

	lkvc_state_t state_q;

	// search words between cells; entry 0 feeds the first cell
	lkvc_tok_t        tok_s [ENTRIES+1];
	logic [IDX_W-1:0] vic_s [ENTRIES+1];

	lkvc_tok_t          tok_in_s1;     // fresh word, registered
	logic [VAL_W-1:0]   set_val_q;     // value of the set being searched
	logic [STAMP_W-1:0] stamp_q;
	logic [VAL_W-1:0]   res_q;         // result parked while the output is full
	logic               out_vld_q;
	logic [VAL_W-1:0]   out_val_q;

	logic             acc;
	logic             launch;
	logic             scan_done;
	logic             out_free;
	logic             res_load;
	logic [VAL_W-1:0] found_val;
	lkvc_wr_t         wr;
	lkvc_tok_t        tok_in;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	// an ignored set is taken and dropped at once
	assign launch   = acc && (action == ACT_GET ||
		(node_id != '0 && rssi_in != '0));

	assign scan_done = tok_s[ENTRIES].vld;
	assign out_free  = !out_vld_q || !out_stall;
	assign found_val = tok_s[ENTRIES].hit ? tok_s[ENTRIES].hit_val : '0;

	// output register loads a get result, fresh from the row or parked
	assign res_load = out_free && ((state_q == ST_SCAN && scan_done && tok_s[ENTRIES].is_get) ||
		state_q == ST_HOLD);

	// fresh search word
	always_comb begin
		tok_in           = '0;
		tok_in.vld       = launch;
		tok_in.is_get    = (action == ACT_GET);
		tok_in.key       = node_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_in_s1 <= '0;
		end else begin
			tok_in_s1 <= tok_in;
		end
	end

	assign tok_s[0] = tok_in_s1;
	assign vic_s[0] = '0;

	always_ff @(posedge clk) begin
		if (acc) begin
			set_val_q <= rssi_in;
		end
	end

	// write broadcast straight from the word leaving the last cell; the
	// FSM returns to idle on the same edge, so no search sees a stale slot
	always_comb begin
		wr.en    = scan_done && !tok_s[ENTRIES].is_get;
		wr.hit   = tok_s[ENTRIES].hit;
		wr.key   = tok_s[ENTRIES].key;
		wr.val   = set_val_q;
		wr.stamp = stamp_q + STAMP_W'(1);
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_i     (tok_s[i]),
			.vic_idx_i (vic_s[i]),
			.tok_o     (tok_s[i+1]),
			.vic_idx_o (vic_s[i+1]),
			.wr_i      (wr),
			.wr_idx_i  (vic_s[ENTRIES])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (wr.en) begin
			stamp_q <= wr.stamp;
		end
	end

	// control: idle -> scan -> (hold while the output word is stalled) -> idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (!tok_s[ENTRIES].is_get || out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && scan_done) begin
			res_q <= found_val;
		end
		if (res_load) begin
			out_val_q <= (state_q == ST_HOLD) ? res_q : found_val;
		end
	end

	assign out_valid   = out_vld_q;
	assign stored_rssi = out_val_q;

endmodule

FILE: rtl/lkvc_checker.sv
// Port-level checks for the LRU keyed value cache, bound to the top level.
// Depends on lkvc_pkg.
module lkvc_checker import lkvc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    action,
	input logic [KEY_W-1:0]        node_id,
	input logic signed [VAL_W-1:0] rssi_in,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] stored_rssi
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stored_rssi))
		else $error("output word changed under stall");

	// a get or an effective set keeps the block busy for the scan
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_GET ||
		(node_id != '0 && rssi_in != '0)) |=> in_stall)
		else $error("block not busy after a searching word");

	// an ignored set leaves the input open
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_SET &&
		(node_id == '0 || rssi_in == '0) |=> !in_stall)
		else $error("ignored set stalled the input");

	// a result appears only at the end of a scan
	a_res_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a scan");

endmodule

bind lru_keyed_value_cache lkvc_checker u_lkvc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.action      (action),
	.node_id     (node_id),
	.rssi_in     (rssi_in),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.stored_rssi (stored_rssi)
);
